// ===== sv/utc_ldt_pkg.sv =====
`timescale 1ns / 1ps

package utc_ldt_pkg;

    // Field widths
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int TZ_W     = 5;

    // Signed working width of hour + offset (range -16..46)
    localparam int HSUM_W = 7;

    typedef logic [YEAR_W-1:0]          t_year;
    typedef logic [MONTH_W-1:0]         t_month;
    typedef logic [DAY_W-1:0]           t_day;
    typedef logic [HOUR_W-1:0]          t_hour;
    typedef logic [MINUTE_W-1:0]        t_minute;
    typedef logic [SECOND_W-1:0]        t_second;
    typedef logic signed [TZ_W-1:0]     t_tz;
    typedef logic signed [HSUM_W-1:0]   t_hsum;

    localparam t_hsum HOURS_PER_DAY = 7'sd24;

    // Month codes
    localparam t_month MONTH_JAN = 4'd1;
    localparam t_month MONTH_FEB = 4'd2;
    localparam t_month MONTH_APR = 4'd4;
    localparam t_month MONTH_JUN = 4'd6;
    localparam t_month MONTH_SEP = 4'd9;
    localparam t_month MONTH_NOV = 4'd11;
    localparam t_month MONTH_DEC = 4'd12;

    // Month lengths
    localparam t_day DAYS_FEB      = 5'd28;
    localparam t_day DAYS_FEB_LEAP = 5'd29;
    localparam t_day DAYS_SHORT    = 5'd30;
    localparam t_day DAYS_LONG     = 5'd31;
    localparam t_day DAY_FIRST     = 5'd1;

    // Year 2100 as an offset from 2000: divisible by 4 but not a leap year
    localparam t_year YEAR_CENTURY = 7'd100;

    // Gregorian rule on year+2000; year is 1..127 on the valid path, so the
    // only century inside the range is 2100
    function automatic logic f_is_leap(input t_year year);
        f_is_leap = (year[1:0] == 2'b00) && (year != YEAR_CENTURY);
    endfunction

    // Days in a month; codes outside the calendar count as long months
    function automatic t_day f_month_len(input t_month month, input logic leap);
        t_day len;
        case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
            MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            default:   len = DAYS_LONG;
        endcase
        f_month_len = len;
    endfunction

endpackage

// ===== sv/utc_to_local_date_time_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// --------  ---------  -------------------------  --------------------------------------
// request   in         i_valid / o_in_stall       i_year_in .. i_second_in
// result    out        o_out_valid / i_out_stall  o_year_out .. o_second_out
// config    in         i_cfg_wr_en                i_cfg_wr_data (signed hour offset)
//
// Three register stages: hour add and shift direction, month lengths and
// rollover flags, then the final date select into the output register.
// One request per cycle while o_in_stall is low; an accepted request passes through
// stage 1, stage 2 and the output register before it shows on o_out_valid.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and the request side stalls only when all three stages are full
// and the result is stalled. Reset (synchronous, active low) empties the
// pipeline and sets the offset to zero.
module utc_to_local_date_time_unit
    import utc_ldt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          i_cfg_wr_en,
    input  t_tz           i_cfg_wr_data,

    input  logic          i_valid,
    output logic          o_in_stall,
    input  t_year         i_year_in,
    input  t_month        i_month_in,
    input  t_day          i_day_in,
    input  t_hour         i_hour_in,
    input  t_minute       i_minute_in,
    input  t_second       i_second_in,

    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_year         o_year_out,
    output t_month        o_month_out,
    output t_day          o_day_out,
    output t_hour         o_hour_out,
    output t_minute       o_minute_out,
    output t_second       o_second_out
);

    // Offset register
    t_tz r_tz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= '0;
        end else if (i_cfg_wr_en) begin
            r_tz <= i_cfg_wr_data;
        end
    end

    // Stage enables
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    assign adv3       = !r_v3 || !i_out_stall;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign o_in_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // ---------------- Stage 1: hour add, shift direction ----------------
    t_hsum n_sum;
    t_hsum n_sum_fwd;
    t_hsum n_sum_bwd;
    logic  n_bad;
    logic  n_fwd;
    logic  n_bwd;
    t_hour n_hour;

    assign n_sum     = $signed({2'b00, i_hour_in}) + $signed({{2{r_tz[TZ_W-1]}}, r_tz});
    assign n_sum_fwd = n_sum - HOURS_PER_DAY;
    assign n_sum_bwd = n_sum + HOURS_PER_DAY;
    assign n_bad     = (i_year_in == '0) || (i_month_in == '0) || (i_day_in == '0);
    assign n_fwd     = !n_bad && (n_sum >= HOURS_PER_DAY);
    assign n_bwd     = !n_bad && (n_sum < 0);

    always_comb begin
        if (n_bad) begin
            n_hour = i_hour_in;
        end else if (n_fwd) begin
            n_hour = n_sum_fwd[HOUR_W-1:0];
        end else if (n_bwd) begin
            n_hour = n_sum_bwd[HOUR_W-1:0];
        end else begin
            n_hour = n_sum[HOUR_W-1:0];
        end
    end

    t_year   r1_year;
    t_month  r1_month;
    t_day    r1_day;
    t_hour   r1_hour;
    t_minute r1_minute;
    t_second r1_second;
    logic    r1_fwd, r1_bwd;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_year   <= i_year_in;
            r1_month  <= i_month_in;
            r1_day    <= i_day_in;
            r1_hour   <= n_hour;
            r1_minute <= i_minute_in;
            r1_second <= i_second_in;
            r1_fwd    <= n_fwd;
            r1_bwd    <= n_bwd;
        end
    end

    // ---------------- Stage 2: month lengths, rollover flags ----------------
    logic   n_leap;
    t_month n_prev_mon;
    t_day   n_len_cur;
    t_day   n_len_prev;
    logic   n_roll;
    logic   n_first;

    assign n_leap     = f_is_leap(r1_year);
    assign n_prev_mon = r1_month - MONTH_JAN;
    assign n_len_cur  = f_month_len(r1_month, n_leap);
    assign n_len_prev = f_month_len(n_prev_mon, n_leap);
    // day + 1 > length, i.e. day >= length
    assign n_roll     = (r1_day >= n_len_cur);
    assign n_first    = (r1_day == DAY_FIRST);

    t_year   r2_year;
    t_month  r2_month;
    t_day    r2_day;
    t_hour   r2_hour;
    t_minute r2_minute;
    t_second r2_second;
    logic    r2_fwd, r2_bwd;
    logic    r2_roll, r2_first;
    t_day    r2_len_prev;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_year     <= r1_year;
            r2_month    <= r1_month;
            r2_day      <= r1_day;
            r2_hour     <= r1_hour;
            r2_minute   <= r1_minute;
            r2_second   <= r1_second;
            r2_fwd      <= r1_fwd;
            r2_bwd      <= r1_bwd;
            r2_roll     <= n_roll;
            r2_first    <= n_first;
            r2_len_prev <= n_len_prev;
        end
    end

    // ---------------- Stage 3: date select ----------------
    t_year  n_year;
    t_month n_month;
    t_day   n_day;

    always_comb begin
        n_year  = r2_year;
        n_month = r2_month;
        n_day   = r2_day;
        if (r2_fwd) begin
            if (r2_roll) begin
                n_day = DAY_FIRST;
                if (r2_month == MONTH_DEC) begin
                    n_month = MONTH_JAN;
                    n_year  = r2_year + 1'b1;
                end else begin
                    n_month = r2_month + 1'b1;
                end
            end else begin
                n_day = r2_day + 1'b1;
            end
        end else if (r2_bwd) begin
            if (r2_first) begin
                n_day = r2_len_prev;
                // January steps back into December of the previous year
                if (r2_month == MONTH_JAN) begin
                    n_month = MONTH_DEC;
                    n_year  = r2_year - 1'b1;
                end else begin
                    n_month = r2_month - 1'b1;
                end
            end else begin
                n_day = r2_day - 1'b1;
            end
        end
    end

    // Output register
    t_year   r_year_out;
    t_month  r_month_out;
    t_day    r_day_out;
    t_hour   r_hour_out;
    t_minute r_minute_out;
    t_second r_second_out;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_year_out   <= n_year;
            r_month_out  <= n_month;
            r_day_out    <= n_day;
            r_hour_out   <= r2_hour;
            r_minute_out <= r2_minute;
            r_second_out <= r2_second;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_year_out   = r_year_out;
    assign o_month_out  = r_month_out;
    assign o_day_out    = r_day_out;
    assign o_hour_out   = r_hour_out;
    assign o_minute_out = r_minute_out;
    assign o_second_out = r_second_out;

endmodule

// ===== sv/utc_ldt_checker.sv =====
`timescale 1ns / 1ps

module utc_ldt_checker
    import utc_ldt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_in_stall,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_year   o_year_out,
    input t_month  o_month_out,
    input t_day    o_day_out,
    input t_hour   o_hour_out,
    input t_minute o_minute_out,
    input t_second o_second_out
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Request side only backs up when a full pipeline faces a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without result back-pressure");

    // A shifted date always yields a legal hour; only pass-through keeps a raw one
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_hour_out > 5'd23)) |->
            ((o_year_out == '0) || (o_month_out == '0) || (o_day_out == '0)))
        else $error("out-of-range hour on a converted date");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_year_out) && $stable(o_month_out) &&
             $stable(o_day_out) && $stable(o_hour_out) &&
             $stable(o_minute_out) && $stable(o_second_out)))
        else $error("stalled result changed");

endmodule

bind utc_to_local_date_time_unit utc_ldt_checker u_utc_ldt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_year_out   (o_year_out),
    .o_month_out  (o_month_out),
    .o_day_out    (o_day_out),
    .o_hour_out   (o_hour_out),
    .o_minute_out (o_minute_out),
    .o_second_out (o_second_out)
);
